@@ rtl/csl_pkg.sv @@
// Shared types and constants for the cursor sequence list.
// No dependencies; compiled first.
package csl_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int GROUP_SIZE    = 8;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 3'd0,
		CMD_ADVANCE = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_ATTACH  = 3'd3,
		CMD_REMOVE  = 3'd4,
		CMD_READ    = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
	} ctrl_t;

endpackage

@@ rtl/csl_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Depends on csl_pkg for field widths.
interface csl_cmd_if;
	import csl_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [VALUE_W-1:0] value;

	modport source (output valid, cmd, value, input ready);
	modport sink (input valid, cmd, value, output ready);
endinterface

interface csl_res_if;
	import csl_pkg::*;
	logic               valid;
	logic               ready;
	logic               has_current;
	logic [VALUE_W-1:0] current_value;
	logic [COUNT_W-1:0] item_count;
	logic [STAT_W-1:0]  status;

	modport source (output valid, has_current, current_value, item_count, status,
		input ready);
	modport sink (input valid, has_current, current_value, item_count, status,
		output ready);
endinterface

@@ rtl/csl_cell.sv @@
// One storage cell of the list chain: holds one word, shifts to or from its neighbors.
// Depends on csl_pkg for the chain operation type.
module csl_cell #(
	parameter int IDX       = 0,
	parameter int WORD_BITS = csl_pkg::WORD_BITS_DEF,
	parameter int PW        = 7
) (
	input  logic                 clk,
	input  csl_pkg::op_t         op,
	input  logic [PW-1:0]        pos,
	input  logic [WORD_BITS-1:0] word,
	input  logic [WORD_BITS-1:0] left,
	input  logic [WORD_BITS-1:0] right,
	input  logic [PW-1:0]        cursor,
	input  logic                 has,
	output logic [WORD_BITS-1:0] data,
	output logic [WORD_BITS-1:0] rd
);
	import csl_pkg::*;

	localparam logic [PW-1:0] IDX_P = PW'(IDX);

	logic [WORD_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_INS: begin
				if (IDX_P > pos)
					data_q <= left;
				else if (IDX_P == pos)
					data_q <= word;
			end
			OP_REM: begin
				if (IDX_P >= pos)
					data_q <= right;
			end
			default: ;
		endcase
	end

	assign data = data_q;
	assign rd   = (has && IDX_P == cursor) ? data_q : '0;

endmodule

@@ rtl/csl_ctrl.sv @@
// Cursor and count control: decodes a command into a chain operation and a status.
// Depends on csl_pkg for command, status and operation types.
module csl_ctrl #(
	parameter int MAX_ITEMS = csl_pkg::MAX_ITEMS_DEF,
	parameter int PW        = $clog2(MAX_ITEMS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [csl_pkg::CMD_W-1:0] cmd,
	output csl_pkg::ctrl_t           ctrl,
	output logic [PW-1:0]            pos,
	output logic [PW-1:0]            cursor,
	output logic [PW-1:0]            count,
	output logic                     has
);
	import csl_pkg::*;

	localparam logic [PW-1:0] MAX_P = PW'(MAX_ITEMS);
	localparam logic [PW-1:0] ONE   = PW'(1);

	logic [PW-1:0] count_q, cursor_q;
	logic [PW-1:0] count_d, cursor_d;
	logic          full;

	assign has  = cursor_q < count_q;
	assign full = count_q >= MAX_P;

	always_comb begin
		count_d     = count_q;
		cursor_d    = cursor_q;
		pos         = '0;
		ctrl.op     = OP_HOLD;
		ctrl.status = ST_OK;
		if (accept) begin
			case (cmd_t'(cmd))
				CMD_START: cursor_d = '0;
				CMD_ADVANCE: begin
					if (has)
						cursor_d = cursor_q + ONE;
					else
						ctrl.status = ST_NONE;
				end
				CMD_INSERT: begin
					if (full) begin
						ctrl.status = ST_FULL;
					end else begin
						pos      = has ? cursor_q : '0;
						cursor_d = pos;
						count_d  = count_q + ONE;
						ctrl.op  = OP_INS;
					end
				end
				CMD_ATTACH: begin
					if (full) begin
						ctrl.status = ST_FULL;
					end else begin
						pos      = has ? cursor_q + ONE : count_q;
						cursor_d = pos;
						count_d  = count_q + ONE;
						ctrl.op  = OP_INS;
					end
				end
				CMD_REMOVE: begin
					if (has) begin
						pos     = cursor_q;
						count_d = count_q - ONE;
						ctrl.op = OP_REM;
					end else begin
						ctrl.status = ST_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	assign cursor = cursor_q;
	assign count  = count_q;

endmodule

@@ rtl/cursor_sequence_list_top.sv @@
// Cursor sequence list: a chain of word cells with a cursor; one result per command.
// The result passes through the update, group OR and final OR register stages after the command transaction.
// Throughput: one command per cycle while the result side keeps up; a stalled
// result stalls the whole pipe and the command side with it.
// Reset clears count, cursor and pipeline valids; cell storage is not cleared.
// Depends on csl_pkg, csl_if, csl_ctrl and csl_cell.
module cursor_sequence_list_top #(
	parameter int MAX_ITEMS = csl_pkg::MAX_ITEMS_DEF,
	parameter int WORD_BITS = csl_pkg::WORD_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	csl_cmd_if.sink   cmd_ch,
	csl_res_if.source res_ch
);
	import csl_pkg::*;

	localparam int PW   = $clog2(MAX_ITEMS + 1);
	localparam int NGRP = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;

	logic                 en, accept;
	ctrl_t                ctrl;
	logic [PW-1:0]        pos, cursor, count;
	logic                 has;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] data [MAX_ITEMS];
	logic [WORD_BITS-1:0] rd   [MAX_ITEMS];
	logic [WORD_BITS-1:0] grp  [NGRP];
	logic [WORD_BITS-1:0] cur_or;

	logic                 v_s1, v_s2, out_v_q;
	status_t              status_s1, status_s2;
	logic [WORD_BITS-1:0] grp_s2 [NGRP];
	logic [PW-1:0]        count_s2;
	logic                 has_s2;

	assign en           = !out_v_q || res_ch.ready;
	assign cmd_ch.ready = en;
	assign accept       = cmd_ch.valid && en;
	assign word         = WORD_BITS'(cmd_ch.value);

	csl_ctrl #(.MAX_ITEMS(MAX_ITEMS), .PW(PW)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd_ch.cmd),
		.ctrl   (ctrl),
		.pos    (pos),
		.cursor (cursor),
		.count  (count),
		.has    (has)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [WORD_BITS-1:0] left, right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = data[i-1];
		end
		if (i == MAX_ITEMS - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = data[i+1];
		end
		csl_cell #(.IDX(i), .WORD_BITS(WORD_BITS), .PW(PW)) u_cell (
			.clk    (clk),
			.op     (ctrl.op),
			.pos    (pos),
			.word   (word),
			.left   (left),
			.right  (right),
			.cursor (cursor),
			.has    (has),
			.data   (data[i]),
			.rd     (rd[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++)
			grp[g] = '0;
		for (int i = 0; i < MAX_ITEMS; i++)
			grp[i / GROUP_SIZE] = grp[i / GROUP_SIZE] | rd[i];
	end

	always_comb begin
		cur_or = '0;
		for (int g = 0; g < NGRP; g++)
			cur_or = cur_or | grp_s2[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1            <= ctrl.status;
			status_s2            <= status_s1;
			grp_s2               <= grp;
			count_s2             <= count;
			has_s2               <= has;
			res_ch.has_current   <= has_s2;
			res_ch.current_value <= VALUE_W'(cur_or);
			res_ch.item_count    <= COUNT_W'(count_s2);
			res_ch.status        <= status_s2;
		end
	end

	assign res_ch.valid = out_v_q;

endmodule

@@ rtl/csl_check.sv @@
// Port-level checks for the cursor sequence list, bound to the top level.
// Depends on csl_pkg for status codes and widths.
module csl_check #(
	parameter int MAX_ITEMS = csl_pkg::MAX_ITEMS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        has_current,
	input logic [csl_pkg::VALUE_W-1:0] current_value,
	input logic [csl_pkg::COUNT_W-1:0] item_count,
	input logic [csl_pkg::STAT_W-1:0]  status
);
	import csl_pkg::*;

	localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_ITEMS);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(item_count) && $stable(status))
		else $error("result dropped while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_current |-> current_value == '0)
		else $error("value shown without a current item");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |-> item_count == MAX_C)
		else $error("full status with a list that is not full");

	a_none_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_NONE |-> !has_current)
		else $error("no-current status with a current item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status == ST_OK || status == ST_FULL || status == ST_NONE)
		else $error("undefined status code");

endmodule

bind cursor_sequence_list_top csl_check #(.MAX_ITEMS(MAX_ITEMS)) u_csl_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_ch.valid),
	.res_ready     (res_ch.ready),
	.has_current   (res_ch.has_current),
	.current_value (res_ch.current_value),
	.item_count    (res_ch.item_count),
	.status        (res_ch.status)
);
